/* hdl/lfa_pkg.sv */
package lfa_pkg;

	localparam int ID_W    = 7;
	localparam int ID_SPAN = 128;
	localparam int REQ_W   = 3;
	localparam int STS_W   = 2;
	localparam int CNT_W   = 32;
	localparam int GRP     = 8;
	localparam int GRP_W   = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC    = 3'd0,
		REQ_RELEASE  = 3'd1,
		REQ_WATCH    = 3'd2,
		REQ_LIKE     = 3'd3,
		REQ_DISLIKE  = 3'd4,
		REQ_RD_LIKES = 3'd5,
		REQ_RD_VIEWS = 3'd6,
		REQ_NOP      = 3'd7
	} req_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_VALID = 2'd1,
		STS_FULL      = 2'd2
	} sts_code_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic look;
		logic exec;
	} lfa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} lfa_sts_t;

endpackage

/* hdl/lowest_free_id_allocator_with_counters_core.sv */
// Lowest-free-id allocator with per-entry view, like and dislike counters.
// Input channel: in_valid/in_ready carry req_type and entry_id. Allocate
// takes the lowest free id and clears its counters; release frees an id;
// watch, like and dislike bump a saturating 32-bit counter; the two read
// requests return counts. A request naming an id that is not allocated
// reports "not valid"; allocate on a full pool reports "full".
// Output channel: out_valid/out_ready carry status, id_out and the counts,
// one result per request, in request order.
// Timing: a request is taken in the idle state, the counter memory read and
// the per-group free search are registered in the read state, and the
// update and result register load happen in the exec state. A new request
// is taken only once the idle, read and update steps of the controller
// are through with the last one.
// A finished result waits in the output register while the next request
// is taken; when the receiver stalls, the block holds in its last step.
// Reset frees every id; counter contents are set by allocate.
module lowest_free_id_allocator_with_counters_core
	import lfa_pkg::*;
#(
	parameter int NUM_ENTRIES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  logic [ID_W-1:0]  entry_id,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [STS_W-1:0] status,
	output logic [ID_W-1:0]  id_out,
	output logic [CNT_W-1:0] views_out,
	output logic [CNT_W-1:0] likes_out,
	output logic [CNT_W-1:0] dislikes_out
);

	lfa_cmd_t cmd;
	lfa_sts_t sts;

	// sequencing
	lfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// map, counters and result register
	lfa_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.entry_id     (entry_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.id_out       (id_out),
		.views_out    (views_out),
		.likes_out    (likes_out),
		.dislikes_out (dislikes_out)
	);

endmodule

/* hdl/lfa_ctrl.sv */
module lfa_ctrl
	import lfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lfa_sts_t sts,
	output lfa_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.look    = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.look = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				if (!sts.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/lfa_datapath.sv */
module lfa_datapath
	import lfa_pkg::*;
#(
	parameter int NUM_ENTRIES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lfa_cmd_t         cmd,
	output lfa_sts_t         sts,
	input  logic [REQ_W-1:0] req_type,
	input  logic [ID_W-1:0]  entry_id,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [STS_W-1:0] status,
	output logic [ID_W-1:0]  id_out,
	output logic [CNT_W-1:0] views_out,
	output logic [CNT_W-1:0] likes_out,
	output logic [CNT_W-1:0] dislikes_out
);

	localparam int POOL = (NUM_ENTRIES < ID_SPAN) ? NUM_ENTRIES : ID_SPAN;
	localparam int PW   = $clog2(POOL);
	localparam int NG   = (POOL + GRP - 1) / GRP;
	localparam int MW   = 3 * CNT_W;

	// captured request
	logic [REQ_W-1:0] req_q;
	logic [ID_W-1:0]  id_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			id_q  <= entry_id;
		end
	end

	// allocation map, one bit per reachable id
	logic [POOL-1:0] valid_q;

	// lowest free slot per group of eight, registered
	logic [NG-1:0]    grp_any_d, grp_any_q;
	logic [GRP_W-1:0] grp_low_d [NG];
	logic [GRP_W-1:0] grp_low_q [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any_d[g] = 1'b0;
			grp_low_d[g] = '0;
			for (int b = GRP - 1; b >= 0; b--) begin
				if ((g * GRP + b) < POOL) begin
					if (!valid_q[PW'(g * GRP + b)]) begin
						grp_any_d[g] = 1'b1;
						grp_low_d[g] = GRP_W'(b);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			grp_any_q <= grp_any_d;
			for (int g = 0; g < NG; g++) begin
				grp_low_q[g] <= grp_low_d[g];
			end
		end
	end

	// counter memory: {dislikes, likes, views}
	logic [MW-1:0] mem_q [POOL];
	logic [MW-1:0] rd_q;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			rd_q <= mem_q[id_q[PW-1:0]];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// pick the lowest group that has a free slot
	logic            found;
	logic [ID_W-1:0] alloc_id;

	always_comb begin
		found    = 1'b0;
		alloc_id = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				found    = 1'b1;
				alloc_id = ID_W'(g * GRP) + ID_W'(grp_low_q[g]);
			end
		end
	end

	// request execution
	logic [CNT_W-1:0] views_rd, likes_rd, dislikes_rd;
	logic             ok;
	logic             set_bit, clr_bit;
	logic [PW-1:0]    bit_idx;
	logic [STS_W-1:0] res_status;
	logic [ID_W-1:0]  res_id;
	logic [CNT_W-1:0] res_views, res_likes, res_dislikes;

	assign views_rd    = rd_q[CNT_W-1:0];
	assign likes_rd    = rd_q[2*CNT_W-1:CNT_W];
	assign dislikes_rd = rd_q[3*CNT_W-1:2*CNT_W];
	assign ok = (32'(id_q) < POOL) && valid_q[id_q[PW-1:0]];

	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = id_q[PW-1:0];
		wr_data      = rd_q;
		set_bit      = 1'b0;
		clr_bit      = 1'b0;
		bit_idx      = id_q[PW-1:0];
		res_status   = STS_OK;
		res_id       = id_q;
		res_views    = '0;
		res_likes    = '0;
		res_dislikes = '0;
		case (req_t'(req_q))
			REQ_ALLOC: begin
				if (found) begin
					set_bit = 1'b1;
					bit_idx = alloc_id[PW-1:0];
					wr_en   = 1'b1;
					wr_addr = alloc_id[PW-1:0];
					wr_data = '0;
					res_id  = alloc_id;
				end else begin
					res_status = STS_FULL;
					res_id     = '0;
				end
			end
			REQ_RELEASE, REQ_WATCH, REQ_LIKE, REQ_DISLIKE, REQ_RD_LIKES,
			REQ_RD_VIEWS: begin
				if (!ok) begin
					res_status = STS_NOT_VALID;
				end else begin
					case (req_t'(req_q))
						REQ_RELEASE: clr_bit = 1'b1;
						REQ_WATCH: begin
							wr_en = (views_rd != CNT_MAX);
							wr_data[CNT_W-1:0] = views_rd + 1'b1;
						end
						REQ_LIKE: begin
							wr_en = (likes_rd != CNT_MAX);
							wr_data[2*CNT_W-1:CNT_W] = likes_rd + 1'b1;
						end
						REQ_DISLIKE: begin
							wr_en = (dislikes_rd != CNT_MAX);
							wr_data[3*CNT_W-1:2*CNT_W] = dislikes_rd + 1'b1;
						end
						REQ_RD_LIKES: begin
							res_likes    = likes_rd;
							res_dislikes = dislikes_rd;
						end
						default: res_views = views_rd;
					endcase
				end
			end
			default: ;
		endcase
		if (!cmd.exec) begin
			wr_en   = 1'b0;
			set_bit = 1'b0;
			clr_bit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_bit) begin
			valid_q[bit_idx] <= 1'b1;
		end else if (clr_bit) begin
			valid_q[bit_idx] <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.exec) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status       <= res_status;
			id_out       <= res_id;
			views_out    <= res_views;
			likes_out    <= res_likes;
			dislikes_out <= res_dislikes;
		end
	end

	assign sts.out_busy = out_valid && !out_ready;

endmodule

/* tb/sv/lfa_reply_checker.sv */
module lfa_reply_checker
	import lfa_pkg::*;
#(
	parameter int NUM_ENTRIES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  logic [ID_W-1:0]  entry_id,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [STS_W-1:0] status,
	input  logic [ID_W-1:0]  id_out,
	input  logic [CNT_W-1:0] views_out,
	input  logic [CNT_W-1:0] likes_out,
	input  logic [CNT_W-1:0] dislikes_out,
	output int               mismatches,
	output int               outstanding
);

	localparam int POOL = (NUM_ENTRIES < ID_SPAN) ? NUM_ENTRIES : ID_SPAN;

	typedef struct packed {
		sts_code_t        sts;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] views;
		logic [CNT_W-1:0] likes;
		logic [CNT_W-1:0] dislikes;
	} reply_t;

	// shadow of the allocation map and the per-entry counters
	logic             id_taken    [NUM_ENTRIES];
	logic [CNT_W-1:0] view_cnt    [NUM_ENTRIES];
	logic [CNT_W-1:0] like_cnt    [NUM_ENTRIES];
	logic [CNT_W-1:0] dislike_cnt [NUM_ENTRIES];
	reply_t           reply_q     [$];
	int               err_cnt = 0;

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= 100)
			$display("%0t  mismatch: %s", $time, msg);
	endtask

	// saturating counter step
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// apply one request to the shadow state and return the reply it causes
	function automatic reply_t apply_request(input req_t req, input logic [ID_W-1:0] id);
		reply_t rep;
		logic   hit;
		int     slot;
		rep = '{sts: STS_OK, id: id, views: '0, likes: '0, dislikes: '0};
		hit = 1'b0;
		if (int'(id) < NUM_ENTRIES)
			hit = id_taken[id];
		case (req)
			REQ_ALLOC: begin
				slot = -1;
				for (int i = 0; i < POOL; i++)
					if (!id_taken[i] && slot < 0)
						slot = i;
				if (slot >= 0) begin
					id_taken[slot]    = 1'b1;
					view_cnt[slot]    = '0;
					like_cnt[slot]    = '0;
					dislike_cnt[slot] = '0;
					rep.id            = ID_W'(slot);
				end else begin
					rep.sts = STS_FULL;
					rep.id  = '0;
				end
			end
			REQ_NOP: ;
			default: begin
				if (!hit) begin
					rep.sts = STS_NOT_VALID;
				end else begin
					case (req)
						REQ_RELEASE:  id_taken[id]    = 1'b0;
						REQ_WATCH:    view_cnt[id]    = bump(view_cnt[id]);
						REQ_LIKE:     like_cnt[id]    = bump(like_cnt[id]);
						REQ_DISLIKE:  dislike_cnt[id] = bump(dislike_cnt[id]);
						REQ_RD_LIKES: begin
							rep.likes    = like_cnt[id];
							rep.dislikes = dislike_cnt[id];
						end
						REQ_RD_VIEWS: rep.views = view_cnt[id];
						default: ;
					endcase
				end
			end
		endcase
		return rep;
	endfunction

	// predict on each request transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin : track
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				id_taken[i]    = 1'b0;
				view_cnt[i]    = '0;
				like_cnt[i]    = '0;
				dislike_cnt[i] = '0;
			end
			reply_q.delete();
		end else begin
			if (in_valid && in_ready)
				reply_q.push_back(apply_request(req_t'(req_type), entry_id));
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: status %0d id %0d",
						status, id_out));
				end else begin
					want = reply_q.pop_front();
					if (status !== want.sts)
						report_mismatch($sformatf("status got %0d want %0d (id %0d)",
							status, want.sts, want.id));
					if (id_out !== want.id)
						report_mismatch($sformatf("id_out got %0d want %0d", id_out, want.id));
					if (views_out !== want.views)
						report_mismatch($sformatf("views_out got %0h want %0h (id %0d)",
							views_out, want.views, want.id));
					if (likes_out !== want.likes)
						report_mismatch($sformatf("likes_out got %0h want %0h (id %0d)",
							likes_out, want.likes, want.id));
					if (dislikes_out !== want.dislikes)
						report_mismatch($sformatf("dislikes_out got %0h want %0h (id %0d)",
							dislikes_out, want.dislikes, want.id));
				end
			end
		end
		outstanding <= reply_q.size();
		mismatches  <= err_cnt;
	end

endmodule

/* tb/sv/lowest_free_id_allocator_with_counters_test.sv */
module lowest_free_id_allocator_with_counters_core_test;
	import lfa_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1100;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC} rdy_mode_t;
	typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic [REQ_W-1:0] req_type  = REQ_NOP;
	logic [ID_W-1:0]  entry_id  = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [STS_W-1:0] status;
	logic [ID_W-1:0]  id_out;
	logic [CNT_W-1:0] views_out;
	logic [CNT_W-1:0] likes_out;
	logic [CNT_W-1:0] dislikes_out;
	int               mismatches;
	int               outstanding;

	int               burst_left   = 0;
	logic [ID_W-1:0]  sweep_id     = '0;
	rdy_mode_t        stall_mode   = RDY_ALWAYS;
	int               stall_left   = 0;
	int               stall_period = 2;
	int               stall_phase  = 0;
	int               cycle_cnt;

	// cumulative request weights per mix, indexed by request code
	int mix_cut [3][8] = '{
		'{55, 60, 70, 78, 85, 92, 98, 100},
		'{20, 35, 55, 68, 80, 90, 98, 100},
		'{ 8, 50, 62, 70, 78, 86, 96, 100}
	};

	lowest_free_id_allocator_with_counters_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.entry_id     (entry_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.id_out       (id_out),
		.views_out    (views_out),
		.likes_out    (likes_out),
		.dislikes_out (dislikes_out)
	);

	lfa_reply_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.entry_id     (entry_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.id_out       (id_out),
		.views_out    (views_out),
		.likes_out    (likes_out),
		.dislikes_out (dislikes_out),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver stall pattern: always ready, coin flip, or one ready per period
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode   = rdy_mode_t'($urandom_range(0, 2));
			stall_left   = $urandom_range(10, 80);
			stall_period = $urandom_range(2, 6);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
			default:    out_ready <= (stall_phase % stall_period == 0);
		endcase
	end

	// watchdog
	initial begin
		for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	// one request transfer; bursts of random length with random gaps between
	task automatic issue(input req_t req, input logic [ID_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= req;
		entry_id <= id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// random requests with a given mix; drain releases sweep through all ids
	task automatic run_mix(input mix_t mix, input int n_items);
		int              pick;
		int              k;
		int              sel;
		req_t            req;
		logic [ID_W-1:0] id;
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(0, 99);
			k = 0;
			while (pick >= mix_cut[mix][k]) k++;
			req = req_t'(k);
			sel = $urandom_range(0, 9);
			if (req == REQ_RELEASE && mix == MIX_DRAIN) begin
				id = sweep_id;
				sweep_id++;
			end else if (sel == 0) begin
				id = $urandom_range(0, 1) ? ID_W'(ID_SPAN - 1) : '0;
			end else if (sel < 5) begin
				id = ID_W'($urandom_range(0, 15));
			end else begin
				id = ID_W'($urandom_range(0, ID_SPAN - 1));
			end
			issue(req, id);
		end
	endtask

	initial begin
		int   done;
		int   n;
		mix_t mix;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: allocation order, every request, free and invalid ids, unused code
		issue(REQ_ALLOC, 7'd127);
		issue(REQ_ALLOC, 7'd0);
		issue(REQ_ALLOC, 7'd85);
		issue(REQ_WATCH, 7'd0);
		issue(REQ_LIKE, 7'd0);
		issue(REQ_DISLIKE, 7'd0);
		issue(REQ_RD_LIKES, 7'd0);
		issue(REQ_RD_VIEWS, 7'd0);
		issue(REQ_RELEASE, 7'd1);
		issue(REQ_RD_VIEWS, 7'd1);
		issue(REQ_ALLOC, 7'd42);
		issue(REQ_RD_LIKES, 7'd1);
		issue(REQ_LIKE, 7'd2);
		issue(REQ_LIKE, 7'd2);
		issue(REQ_DISLIKE, 7'd2);
		issue(REQ_RD_LIKES, 7'd2);
		issue(REQ_WATCH, 7'd127);
		issue(REQ_RELEASE, 7'd127);
		issue(REQ_NOP, 7'd127);
		issue(REQ_NOP, 7'd0);
		issue(REQ_RELEASE, 7'd0);
		issue(REQ_RELEASE, 7'd0);
		issue(REQ_RD_LIKES, 7'd0);
		issue(REQ_ALLOC, 7'd127);

		// a long fill first so the pool runs full, then rotating mixes
		run_mix(MIX_FILL, 300);
		done = 300;
		mix  = MIX_CHURN;
		while (done < RANDOM_ITEMS) begin
			n = $urandom_range(60, 200);
			run_mix(mix, n);
			done += n;
			mix = (mix == MIX_DRAIN) ? MIX_FILL : mix_t'(int'(mix) + 1);
		end
		in_valid <= 1'b0;

		// drain outstanding results, then a short quiet tail
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
hdl/lfa_pkg.sv
hdl/lfa_ctrl.sv
hdl/lfa_datapath.sv
hdl/lowest_free_id_allocator_with_counters_core.sv
tb/sv/lfa_reply_checker.sv
tb/sv/lowest_free_id_allocator_with_counters_test.sv
